[src/dns_ar_pkg.sv]
// shared types, constants and helpers for the dns a-record responder
package dns_ar_pkg;

	// largest datagram that is parsed, default for the top-level parameter
	localparam int MAX_DATAGRAM_DEF = 512;

	// fixed header length of a dns message
	localparam int HDR_LEN = 12;

	// number of answer bytes appended to a valid query
	localparam int ANSWER_LEN = 16;

	// depth of the command queue between front and back
	localparam int Q_DEPTH = 4;

	// configuration register map
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_ANSWER_ADDRESS = 1'b0;
	localparam logic [31:0] ANSWER_ADDRESS_RST = 32'hC0A8_0401;

	// rewritten header bytes
	localparam logic [7:0] HDR_FLAGS_HI = 8'h81;
	localparam logic [7:0] HDR_FLAGS_LO = 8'h80;
	localparam logic [7:0] HDR_ANCOUNT_LO = 8'h01;

	// fixed part of the answer record: name pointer, type a, class in, ttl 60, rdlength 4
	localparam logic [7:0] ANSWER_FIXED [HDR_LEN] = '{
		8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h04
	};

	// one queued command from the parser to the emitter
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
		logic       ok;
	} dns_ar_cmd_t;

	// answer byte for a given step of the burst
	function automatic logic [7:0] answer_byte(logic [3:0] step, logic [31:0] addr);
		logic [7:0] b;
		case (step)
			4'd12: b = addr[31:24];
			4'd13: b = addr[23:16];
			4'd14: b = addr[15:8];
			4'd15: b = addr[7:0];
			default: b = ANSWER_FIXED[step];
		endcase
		return b;
	endfunction

endpackage

[src/dns_ar_if.sv]
// stream interfaces for query bytes in and response bytes out

// query byte channel
interface dns_ar_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// response byte channel
interface dns_ar_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       frame_ok;

	modport source (output valid, output out_byte, output frame_end, output frame_ok,
		input ready);
	modport sink (input valid, input out_byte, input frame_end, input frame_ok,
		output ready);
endinterface

[src/dns_ar_front.sv]
// query parser: rewrites header, walks qname labels, judges the frame
module dns_ar_front #(
	parameter int MAX_DATAGRAM = dns_ar_pkg::MAX_DATAGRAM_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	dns_ar_req_if.sink              req,
	input  logic                    q_full,
	output logic                    q_push,
	output dns_ar_pkg::dns_ar_cmd_t q_cmd
);

	localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
	localparam int END_W = $clog2(MAX_DATAGRAM);
	localparam int LBL_W = $clog2(MAX_DATAGRAM + 261);

	logic [POS_W-1:0] pos_q;
	logic [LBL_W-1:0] next_label_q;
	logic [END_W-1:0] name_end_q;
	logic             name_found_q;
	logic             count_nz_q;

	logic             accept;
	logic             in_range;
	logic [POS_W-1:0] pos_nxt;
	logic [LBL_W-1:0] pos_ext;
	logic [LBL_W-1:0] pos_nxt_ext;
	logic [LBL_W-1:0] end_ext;
	logic             send;
	logic [7:0]       o_byte;
	logic             frame_ok;
	logic             hit_label;

	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	// per-byte parse decisions
	always_comb begin
		in_range    = pos_q < POS_W'(MAX_DATAGRAM);
		pos_nxt     = in_range ? pos_q + POS_W'(1) : pos_q;
		pos_ext     = LBL_W'(pos_q);
		pos_nxt_ext = LBL_W'(pos_nxt);
		end_ext     = LBL_W'(name_end_q);
		send        = 1'b0;
		o_byte      = req.data_byte;
		hit_label   = 1'b0;
		if (in_range) begin
			if (pos_q < POS_W'(dns_ar_pkg::HDR_LEN)) begin
				send = 1'b1;
				case (pos_q) inside
					POS_W'(2): o_byte = dns_ar_pkg::HDR_FLAGS_HI;
					POS_W'(3): o_byte = dns_ar_pkg::HDR_FLAGS_LO;
					POS_W'(6): o_byte = 8'h00;
					POS_W'(7): o_byte = dns_ar_pkg::HDR_ANCOUNT_LO;
					[POS_W'(8):POS_W'(11)]: o_byte = 8'h00;
					default: o_byte = req.data_byte;
				endcase
			end else if (!name_found_q) begin
				send      = 1'b1;
				hit_label = pos_ext == next_label_q;
			end else if (pos_ext <= end_ext + LBL_W'(4)) begin
				send = 1'b1;
			end
		end
		// validity judged on the bytes seen including this one
		frame_ok = (pos_nxt >= POS_W'(dns_ar_pkg::HDR_LEN)) && count_nz_q && name_found_q
			&& (end_ext + LBL_W'(5) <= pos_nxt_ext);
	end

	// command to the emitter
	assign q_push       = accept && (send || req.last_byte);
	assign q_cmd.data     = o_byte;
	assign q_cmd.has_byte = send;
	assign q_cmd.last     = req.last_byte;
	assign q_cmd.ok       = frame_ok;

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			next_label_q <= LBL_W'(dns_ar_pkg::HDR_LEN);
			name_end_q   <= '0;
			name_found_q <= 1'b0;
			count_nz_q   <= 1'b0;
		end else if (accept) begin
			if (req.last_byte) begin
				pos_q        <= '0;
				next_label_q <= LBL_W'(dns_ar_pkg::HDR_LEN);
				name_end_q   <= '0;
				name_found_q <= 1'b0;
				count_nz_q   <= 1'b0;
			end else begin
				pos_q <= pos_nxt;
				if (in_range && (pos_q == POS_W'(4) || pos_q == POS_W'(5))
						&& req.data_byte != 8'h00) begin
					count_nz_q <= 1'b1;
				end
				if (hit_label) begin
					if (req.data_byte == 8'h00) begin
						name_found_q <= 1'b1;
						name_end_q   <= END_W'(pos_q);
					end else begin
						next_label_q <= pos_ext + LBL_W'(1) + LBL_W'(req.data_byte);
					end
				end
			end
		end
	end

endmodule

[src/dns_ar_fifo.sv]
// short command queue between parser and emitter
module dns_ar_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  dns_ar_pkg::dns_ar_cmd_t push_cmd,
	input  logic                    pop,
	output logic                    full,
	output logic                    head_valid,
	output dns_ar_pkg::dns_ar_cmd_t head
);

	localparam int IDX_W = $clog2(dns_ar_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(dns_ar_pkg::Q_DEPTH + 1);

	dns_ar_pkg::dns_ar_cmd_t cmd_q [dns_ar_pkg::Q_DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = cnt_q == CNT_W'(dns_ar_pkg::Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = cmd_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(dns_ar_pkg::Q_DEPTH - 1)) ? '0
					: wr_ptr_q + IDX_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(dns_ar_pkg::Q_DEPTH - 1)) ? '0
					: rd_ptr_q + IDX_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[src/dns_ar_back.sv]
// response emitter: copied bytes, answer burst or discard mark
module dns_ar_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [31:0]             answer_address,
	input  logic                    head_valid,
	input  dns_ar_pkg::dns_ar_cmd_t head,
	output logic                    pop,
	dns_ar_rsp_if.source            rsp
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       frame_ok_q;
	logic [3:0] step_q;
	logic       byte_done_q;

	logic       load;
	logic       fire;
	logic [7:0] nxt_byte;
	logic       nxt_end;
	logic       nxt_ok;
	logic       step_last;

	assign load      = !out_valid_q || rsp.ready;
	assign fire      = load && head_valid;
	assign step_last = step_q == 4'(dns_ar_pkg::ANSWER_LEN - 1);

	// pick the next word from the head command
	always_comb begin
		nxt_byte = head.data;
		nxt_end  = 1'b0;
		nxt_ok   = 1'b0;
		pop      = 1'b0;
		if (head.has_byte && !byte_done_q) begin
			pop = fire && !head.last;
		end else if (head.ok) begin
			nxt_byte = dns_ar_pkg::answer_byte(step_q, answer_address);
			nxt_end  = step_last;
			nxt_ok   = step_last;
			pop      = fire && step_last;
		end else begin
			nxt_byte = 8'h00;
			nxt_end  = 1'b1;
			pop      = fire;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q  <= nxt_byte;
			frame_end_q <= nxt_end;
			frame_ok_q  <= nxt_ok;
		end
	end

	// output valid and burst progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
			byte_done_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (fire) begin
				if (head.has_byte && !byte_done_q) begin
					byte_done_q <= head.last;
				end else if (head.ok && !step_last) begin
					step_q <= step_q + 4'(1);
				end else begin
					step_q      <= '0;
					byte_done_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_byte  = out_byte_q;
	assign rsp.frame_end = frame_end_q;
	assign rsp.frame_ok  = frame_ok_q;

endmodule

[src/dns_a_record_responder_top.sv]
// top level of the dns a-record responder
//
// Query bytes enter on req (data_byte, last_byte) with valid/ready, one word
// a cycle. Response words leave on rsp (out_byte, frame_end, frame_ok).
// The header is rewritten in flight, the question is copied, and the rest
// of the datagram is dropped. On the last byte a valid query gets a 16-word
// answer closing with frame_end and frame_ok set; otherwise one discard word
// with frame_end set and frame_ok clear tells the receiver to drop the frame.
// Bytes past MAX_DATAGRAM produce nothing but a last mark still ends the frame.
// Each word passes through the command queue and then the output register.
// Throughput: one byte a cycle in and one word a cycle out while rsp.ready
// is high; the single output register sends one word per cycle, so an answer
// burst holds the emitter for its 16 words while the parser keeps taking
// bytes into a 4-entry command queue; req.ready drops only when it is full.
// A stalled rsp.ready holds the output word and backs up into the queue.
// The answer address is written over the APB port at byte address 0 and
// resets to 192.168.4.1; reset clears the parse and empties the queue.
module dns_a_record_responder_top #(
	parameter int MAX_DATAGRAM = dns_ar_pkg::MAX_DATAGRAM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	dns_ar_req_if.sink                        req,
	dns_ar_rsp_if.source                      rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dns_ar_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	logic [31:0]             answer_address_q;
	logic                    q_full;
	logic                    q_push;
	logic                    q_pop;
	logic                    q_head_valid;
	dns_ar_pkg::dns_ar_cmd_t q_cmd;
	dns_ar_pkg::dns_ar_cmd_t q_head;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == dns_ar_pkg::REG_ANSWER_ADDRESS) ? answer_address_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_address_q <= dns_ar_pkg::ANSWER_ADDRESS_RST;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == dns_ar_pkg::REG_ANSWER_ADDRESS) begin
			answer_address_q <= pwdata;
		end
	end

	// parser
	dns_ar_front #(
		.MAX_DATAGRAM(MAX_DATAGRAM)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_cmd)
	);

	// command queue
	dns_ar_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// emitter
	dns_ar_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.answer_address (answer_address_q),
		.head_valid     (q_head_valid),
		.head           (q_head),
		.pop            (q_pop),
		.rsp            (rsp)
	);

	// a commit word always closes its frame
	a_ok_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.frame_ok |-> rsp.frame_end)
		else $error("frame_ok without frame_end");

	// a last byte always leaves a command waiting for the emitter
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.last_byte |=> q_head_valid)
		else $error("last byte did not reach the queue");

	// the emitter never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head_valid)
		else $error("pop from empty queue");

endmodule

[tb/dns_a_record_responder_top_tb.sv]
`timescale 1ns / 1ps
// testbench for the dns a-record responder: query streams in, checked response words out
module dns_a_record_responder_top_tb;

	localparam int MAX_DG = 64;
	localparam int HEADER_BYTES = 12;
	localparam int ANSWER_BYTES = 16;
	localparam int RANDOM_BYTES_PER_PHASE = 10;
	localparam logic [31:0] ANSWER_ADDR_AT_RESET = 32'hC0A8_0401;
	localparam logic [dns_ar_pkg::CFG_ADDR_W-1:0] ANSWER_ADDR_OFS =
		{dns_ar_pkg::REG_ANSWER_ADDRESS, 2'b00};

	// answer record up to the address: name pointer, type a, class in, ttl 60, rdlength 4
	localparam logic [7:0] RR_HEAD [12] = '{
		8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h00, 8'h3C, 8'h00, 8'h04
	};

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       frame_ok;
	} rsp_word_t;

	logic                                clk;
	logic                                arst_n;
	logic                                psel;
	logic                                penable;
	logic                                pwrite;
	logic [dns_ar_pkg::CFG_ADDR_W-1:0]   paddr;
	logic [31:0]                         pwdata;
	logic [31:0]                         prdata;
	logic                                pready;

	dns_ar_req_if req_ch ();
	dns_ar_rsp_if rsp_ch ();

	dns_a_record_responder_top #(
		.MAX_DATAGRAM(MAX_DG)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// response words still owed by the block, oldest first
	rsp_word_t   response_q[$];
	// datagram under construction
	logic [7:0]  frame_bytes[$];

	// parse state of the responder as seen from outside
	logic [9:0]  byte_pos;
	logic [10:0] next_label_pos;
	logic [9:0]  name_end_pos;
	logic        name_seen;
	logic        qdcount_nz;
	logic [31:0] answer_addr;

	int          copied_bytes;
	int          fail_count;
	int          send_idle_pct;
	int          recv_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver stalls
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each accepted word against the oldest expectation
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (response_q.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %h/%b/%b", $time,
					rsp_ch.out_byte, rsp_ch.frame_end, rsp_ch.frame_ok);
				fail_count++;
			end else begin
				want = response_q.pop_front();
				if (rsp_ch.out_byte !== want.out_byte || rsp_ch.frame_end !== want.frame_end ||
						rsp_ch.frame_ok !== want.frame_ok) begin
					$display("%0t: word mismatch, expected %h/%b/%b, got %h/%b/%b", $time,
						want.out_byte, want.frame_end, want.frame_ok,
						rsp_ch.out_byte, rsp_ch.frame_end, rsp_ch.frame_ok);
					fail_count++;
				end
			end
		end
	end

	function automatic void clear_parse();
		byte_pos = '0;
		next_label_pos = 11'(HEADER_BYTES);
		name_end_pos = '0;
		name_seen = 1'b0;
		qdcount_nz = 1'b0;
	endfunction

	function automatic void owe_word(logic [7:0] b, logic fend, logic fok);
		rsp_word_t w;
		w.out_byte = b;
		w.frame_end = fend;
		w.frame_ok = fok;
		response_q.push_back(w);
	endfunction

	// expected response words for one accepted query byte
	function automatic void respond_to_byte(logic [7:0] b, logic last);
		logic [9:0] p;
		logic [7:0] o;
		logic [7:0] a;
		if (byte_pos < MAX_DG) begin
			p = byte_pos;
			byte_pos = p + 10'd1;
			if (p < HEADER_BYTES) begin
				// header rewrite: flags, an answer count of one, and zeroed ns/ar counts
				case (p)
					10'd2: o = 8'h81;
					10'd3: o = 8'h80;
					10'd6: o = 8'h00;
					10'd7: o = 8'h01;
					default: o = (p >= 10'd8) ? 8'h00 : b;
				endcase
				if ((p == 10'd4 || p == 10'd5) && b != 8'h00)
					qdcount_nz = 1'b1;
				owe_word(o, 1'b0, 1'b0);
				copied_bytes++;
			end else if (!name_seen) begin
				// walk label lengths until the root byte
				if (p == next_label_pos) begin
					if (b == 8'h00) begin
						name_seen = 1'b1;
						name_end_pos = p;
					end else begin
						next_label_pos = p + 11'd1 + b;
					end
				end
				owe_word(b, 1'b0, 1'b0);
				copied_bytes++;
			end else if (p <= name_end_pos + 4) begin
				owe_word(b, 1'b0, 1'b0);
				copied_bytes++;
			end
		end
		if (last) begin
			if (byte_pos >= HEADER_BYTES && qdcount_nz && name_seen &&
					int'(name_end_pos) + 5 <= int'(byte_pos)) begin
				for (int i = 0; i < ANSWER_BYTES; i++) begin
					a = (i < 12) ? RR_HEAD[i] : answer_addr[8 * (15 - i) +: 8];
					owe_word(a, i == ANSWER_BYTES - 1, i == ANSWER_BYTES - 1);
				end
			end else begin
				owe_word(8'h00, 1'b1, 1'b0);
			end
			clear_parse();
		end
	endfunction

	// send one query byte, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data_byte <= b;
		req_ch.last_byte <= last;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		respond_to_byte(b, last);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	// wait until every owed word is out, then let the pipeline settle
	task automatic wait_response_drained();
		req_ch.valid <= 1'b0;
		while (response_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write the answer address, then read it back
	task automatic write_answer_address(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ANSWER_ADDR_OFS;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		answer_addr = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== value) begin
			$display("%0t: answer address readback, expected %h, got %h", $time, value, prdata);
			fail_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// random header; the question count is nonzero unless a zero one is allowed and drawn
	function automatic void build_header(bit allow_zero_count);
		frame_bytes.delete();
		for (int i = 0; i < HEADER_BYTES; i++)
			frame_bytes.push_back(8'($urandom_range(255)));
		if (allow_zero_count && $urandom_range(9) == 0) begin
			frame_bytes[4] = 8'h00;
			frame_bytes[5] = 8'h00;
		end else if (frame_bytes[4] == 8'h00 && frame_bytes[5] == 8'h00) begin
			frame_bytes[5] = 8'h01;
		end
	endfunction

	// well-formed query with random labels, type/class and some trailing bytes
	function automatic void build_query(int max_label, bit allow_zero_count);
		int n_labels;
		int len;
		build_header(allow_zero_count);
		n_labels = $urandom_range(3);
		for (int i = 0; i < n_labels; i++) begin
			len = $urandom_range(1, max_label);
			frame_bytes.push_back(8'(len));
			repeat (len) frame_bytes.push_back(8'($urandom_range(255)));
		end
		frame_bytes.push_back(8'h00);
		repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
		repeat ($urandom_range(5)) frame_bytes.push_back(8'($urandom_range(255)));
	endfunction

	// root name only, header and type/class all ones
	task automatic test_min_query();
		frame_bytes.delete();
		repeat (HEADER_BYTES) frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		repeat (4) frame_bytes.push_back(8'hFF);
		send_frame();
	endtask

	// a lone byte, then a query one byte short of its class
	task automatic test_invalid_frames();
		frame_bytes.delete();
		frame_bytes.push_back(8'h00);
		send_frame();
		frame_bytes.delete();
		repeat (HEADER_BYTES) frame_bytes.push_back(8'h00);
		frame_bytes[5] = 8'h01;
		frame_bytes.push_back(8'h00);
		repeat (3) frame_bytes.push_back(8'h01);
		send_frame();
	endtask

	// label length with both top bits set is a plain length, so the zero after it ends nothing
	task automatic test_wide_label();
		build_header(1'b0);
		frame_bytes.push_back(8'hC0);
		frame_bytes.push_back(8'h00);
		repeat (4) frame_bytes.push_back(8'($urandom_range(255)));
		send_frame();
	endtask

	// answer address at both ends of its range
	task automatic test_address_extremes();
		wait_response_drained();
		write_answer_address(32'hFFFF_FFFF);
		build_query(2, 1'b0);
		send_frame();
		wait_response_drained();
		write_answer_address(32'h0000_0000);
		build_query(2, 1'b0);
		send_frame();
	endtask

	// frames reaching and passing the datagram limit
	task automatic test_oversize();
		// last mark on the final byte that is still parsed
		build_query(4, 1'b0);
		while (frame_bytes.size() < MAX_DG)
			frame_bytes.push_back(8'($urandom_range(255)));
		send_frame();
		// last mark beyond the limit, judged on the first bytes
		build_query(4, 1'b0);
		while (frame_bytes.size() < MAX_DG + 2)
			frame_bytes.push_back(8'($urandom_range(255)));
		send_frame();
	endtask

	// mostly well-formed queries, some cut short, some noise
	task automatic test_random_traffic(input int send_pct, input int recv_pct);
		int start;
		int kind;
		int keep;
		wait_response_drained();
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		write_answer_address($urandom());
		start = copied_bytes;
		while (copied_bytes - start < RANDOM_BYTES_PER_PHASE) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				build_query(6, 1'b1);
			end else if (kind < 85) begin
				build_query(6, 1'b1);
				keep = $urandom_range(1, frame_bytes.size() - 1);
				while (frame_bytes.size() > keep)
					void'(frame_bytes.pop_back());
			end else begin
				frame_bytes.delete();
				repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom_range(255)));
			end
			send_frame();
		end
	endtask

	// test sequence
	initial begin
		req_ch.valid <= 1'b0;
		req_ch.data_byte <= 8'h00;
		req_ch.last_byte <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		clear_parse();
		answer_addr = ANSWER_ADDR_AT_RESET;
		copied_bytes = 0;
		fail_count = 0;
		send_idle_pct = 35;
		recv_idle_pct = 49;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_min_query();
		test_invalid_frames();
		test_wide_label();
		test_address_extremes();
		test_oversize();
		test_random_traffic(35, 49);
		test_random_traffic(49, 35);
		test_random_traffic(0, 0);

		wait_response_drained();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
